[design/spcl_pkg.sv]
// Shared constants for the saturation preserving color lerp.
// No dependencies; used by spcl_div_pipe and saturation_preserving_color_lerp.
package spcl_pkg;

   localparam int LANES      = 3;        // red, green, blue
   localparam int CH_BITS    = 8;
   localparam int BLEND_BITS = 17;

   localparam int RED   = 0;
   localparam int GREEN = 1;
   localparam int BLUE  = 2;

   // t = 1.0 in the input Q1.16 format; larger codes saturate here
   localparam logic [BLEND_BITS-1:0] T_FULL = 17'd65536;

endpackage

[design/spcl_div_pipe.sv]
// Pipelined restoring divider, one quotient bit per stage, several lanes
// sharing one divisor, with a sideband that travels along. Uses spcl_pkg.
module spcl_div_pipe #(
   parameter int NW = 40,   // dividend width
   parameter int DW = 24,   // divisor width
   parameter int QW = 17,   // quotient bits (quotient known to fit)
   parameter int SW = 8     // sideband width
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          enable,
   input  logic          in_valid,
   input  logic [NW-1:0] in_num [spcl_pkg::LANES],
   input  logic [DW-1:0] in_den,
   input  logic [SW-1:0] in_side,
   output logic          out_valid,
   output logic [QW-1:0] out_quot [spcl_pkg::LANES],
   output logic [SW-1:0] out_side
);

   logic [DW:0]   rem_ff  [QW][spcl_pkg::LANES];
   logic [QW-1:0] xlo_ff  [QW][spcl_pkg::LANES];
   logic [QW-1:0] quo_ff  [QW][spcl_pkg::LANES];
   logic [DW-1:0] den_ff  [QW];
   logic [SW-1:0] side_ff [QW];
   logic [QW-1:0] vld_ff;

   for (genvar k = 0; k < QW; k++) begin : g_stage
      logic [DW:0]   rem_prev  [spcl_pkg::LANES];
      logic [QW-1:0] xlo_prev  [spcl_pkg::LANES];
      logic [QW-1:0] quo_prev  [spcl_pkg::LANES];
      logic [DW-1:0] den_prev;
      logic [SW-1:0] side_prev;
      logic          vld_prev;
      logic [DW:0]   rem_in    [spcl_pkg::LANES];
      logic [QW-1:0] xlo_in    [spcl_pkg::LANES];
      logic [QW-1:0] quo_in    [spcl_pkg::LANES];

      // stage inputs: module ports for the first stage, else previous stage
      if (k == 0) begin : g_first
         always_comb begin
            for (int l = 0; l < spcl_pkg::LANES; l++) begin
               rem_prev[l] = (DW+1)'(in_num[l][NW-1:QW]);
               xlo_prev[l] = in_num[l][QW-1:0];
               quo_prev[l] = '0;
            end
            den_prev  = in_den;
            side_prev = in_side;
            vld_prev  = in_valid;
         end
      end else begin : g_next
         always_comb begin
            for (int l = 0; l < spcl_pkg::LANES; l++) begin
               rem_prev[l] = rem_ff[k-1][l];
               xlo_prev[l] = xlo_ff[k-1][l];
               quo_prev[l] = quo_ff[k-1][l];
            end
            den_prev  = den_ff[k-1];
            side_prev = side_ff[k-1];
            vld_prev  = vld_ff[k-1];
         end
      end

      // bring in one dividend bit, trial subtract
      always_comb begin
         logic [DW:0] trial;
         for (int l = 0; l < spcl_pkg::LANES; l++) begin
            trial = {rem_prev[l][DW-1:0], xlo_prev[l][QW-1]};
            xlo_in[l] = {xlo_prev[l][QW-2:0], 1'b0};
            if (trial >= {1'b0, den_prev}) begin
               rem_in[l] = trial - {1'b0, den_prev};
               quo_in[l] = {quo_prev[l][QW-2:0], 1'b1};
            end else begin
               rem_in[l] = trial;
               quo_in[l] = {quo_prev[l][QW-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (enable) begin
            vld_ff[k] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[k]  <= rem_in;
            xlo_ff[k]  <= xlo_in;
            quo_ff[k]  <= quo_in;
            den_ff[k]  <= den_prev;
            side_ff[k] <= side_prev;
         end
      end
   end

   assign out_valid = vld_ff[QW-1];
   assign out_quot  = quo_ff[QW-1];
   assign out_side  = side_ff[QW-1];

endmodule

[design/saturation_preserving_color_lerp.sv]
// Top level of the saturation preserving RGBA8 color lerp.
// Depends on spcl_pkg and spcl_div_pipe.
//
//  channel | ports  | beat contents
//  input   | req_*  | start RGBA, end RGBA, blend factor t (Q1.16)
//  output  | rsp_*  | blended RGBA
//
// One beat per cycle in and out while rsp_tready does not stall the output.
// The datapath holds two bit-per-stage dividers (midpoint
// normalization and rescale to the target maximum). Synchronous reset
// clears only the valid bits. A stall on rsp_tready freezes every stage
// and drops req_tready in the same cycle.
module saturation_preserving_color_lerp #(
   parameter int FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // start_red, start_green, start_blue, start_alpha, end_red, end_green,
   // end_blue, end_alpha, blend_factor[16:0], 7 zero bits
   input  logic [87:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // out_red, out_green, out_blue, out_alpha
   output logic [31:0] rsp_tdata
);

   localparam int F   = FRAC_BITS;
   localparam int VW  = F + 8;           // color level scaled by 2^F
   localparam int TW  = F + 1;           // t in 0..2^F
   localparam int QW  = F + 1;           // quotients in 0..2^F
   localparam int NW1 = VW + F;
   localparam int NW2 = QW + F;
   localparam int SW1 = 2 * spcl_pkg::LANES * spcl_pkg::CH_BITS + 9 + 8 + 1 + TW + 2;
   localparam int SW2 = SW1 + 1;
   localparam logic [VW-1:0] FULL = VW'(255) << F;

   logic adv;

   // ---------------- stage 1: input register ----------------
   logic                              v1_ff;
   logic [spcl_pkg::CH_BITS-1:0]      s1_ff [4];
   logic [spcl_pkg::CH_BITS-1:0]      e1_ff [4];
   logic [spcl_pkg::BLEND_BITS-1:0]   bf1_ff;

   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 4; i++) begin
            s1_ff[i] <= req_tdata[8*i +: 8];
            e1_ff[i] <= req_tdata[32 + 8*i +: 8];
         end
         bf1_ff <= req_tdata[80:64];
      end
   end

   // t, segment, blend weights, alpha, channel averages
   logic [spcl_pkg::BLEND_BITS-1:0] tsat;
   logic [TW-1:0]                   t1;
   logic [F+1:0]                    twot;
   logic [F+1:0]                    one2;
   logic                            seg1;
   logic [TW-1:0]                   dt1;
   logic [TW-1:0]                   w1;
   logic signed [8:0]               da;
   logic signed [F+1:0]             ts;
   logic signed [F+10:0]            asum;
   logic [7:0]                      alpha1;
   logic [8:0]                      sum1 [spcl_pkg::LANES];
   logic [8:0]                      minsum1;
   logic [8:0]                      msum1;
   logic [7:0]                      maxs, maxe;
   logic                            eqrgb1;

   always_comb begin
      tsat = (bf1_ff > spcl_pkg::T_FULL) ? spcl_pkg::T_FULL : bf1_ff;
      t1   = TW'(({{F{1'b0}}, tsat} << F) >> 16);
      twot = {t1, 1'b0};
      one2 = (F+2)'(1) << F;
      seg1 = twot >= one2;
      dt1  = seg1 ? TW'(twot - one2) : TW'(one2 - twot);
      w1   = seg1 ? dt1 : TW'(twot);

      da     = $signed({1'b0, e1_ff[3]}) - $signed({1'b0, s1_ff[3]});
      ts     = $signed({1'b0, t1});
      asum   = da * ts + $signed({3'b000, s1_ff[3], {F{1'b0}}});
      alpha1 = asum[F+7:F];

      for (int i = 0; i < spcl_pkg::LANES; i++) begin
         sum1[i] = {1'b0, s1_ff[i]} + {1'b0, e1_ff[i]};
      end
      minsum1 = sum1[spcl_pkg::RED];
      if (sum1[spcl_pkg::GREEN] < minsum1) minsum1 = sum1[spcl_pkg::GREEN];
      if (sum1[spcl_pkg::BLUE] < minsum1)  minsum1 = sum1[spcl_pkg::BLUE];
      maxs = s1_ff[spcl_pkg::RED];
      if (s1_ff[spcl_pkg::GREEN] > maxs) maxs = s1_ff[spcl_pkg::GREEN];
      if (s1_ff[spcl_pkg::BLUE] > maxs)  maxs = s1_ff[spcl_pkg::BLUE];
      maxe = e1_ff[spcl_pkg::RED];
      if (e1_ff[spcl_pkg::GREEN] > maxe) maxe = e1_ff[spcl_pkg::GREEN];
      if (e1_ff[spcl_pkg::BLUE] > maxe)  maxe = e1_ff[spcl_pkg::BLUE];
      msum1  = {1'b0, maxs} + {1'b0, maxe};
      eqrgb1 = (s1_ff[spcl_pkg::RED] == e1_ff[spcl_pkg::RED])
            && (s1_ff[spcl_pkg::GREEN] == e1_ff[spcl_pkg::GREEN])
            && (s1_ff[spcl_pkg::BLUE] == e1_ff[spcl_pkg::BLUE]);
   end

   // ---------------- stage 2 ----------------
   logic          v2_ff;
   logic [7:0]    sc2_ff [spcl_pkg::LANES];
   logic [7:0]    ec2_ff [spcl_pkg::LANES];
   logic [8:0]    sum2_ff [spcl_pkg::LANES];
   logic [8:0]    minsum2_ff, msum2_ff;
   logic [7:0]    alpha2_ff;
   logic          seg2_ff, eqrgb2_ff;
   logic [TW-1:0] dt2_ff, w2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (adv) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < spcl_pkg::LANES; i++) begin
            sc2_ff[i] <= s1_ff[i];
            ec2_ff[i] <= e1_ff[i];
         end
         sum2_ff    <= sum1;
         minsum2_ff <= minsum1;
         msum2_ff   <= msum1;
         alpha2_ff  <= alpha1;
         seg2_ff    <= seg1;
         eqrgb2_ff  <= eqrgb1;
         dt2_ff     <= dt1;
         w2_ff      <= w1;
      end
   end

   // darkening D = |2t-1| * min average; min average = minsum * 2^(F-1)
   logic [F+9:0] dprod;
   logic [VW-1:0] d2;
   assign dprod = dt2_ff * minsum2_ff;
   assign d2    = dprod[F+8:1];

   // ---------------- stage 3 ----------------
   logic          v3_ff;
   logic [7:0]    sc3_ff [spcl_pkg::LANES];
   logic [7:0]    ec3_ff [spcl_pkg::LANES];
   logic [8:0]    sum3_ff [spcl_pkg::LANES];
   logic [8:0]    msum3_ff;
   logic [7:0]    alpha3_ff;
   logic          seg3_ff, eqrgb3_ff;
   logic [TW-1:0] w3_ff;
   logic [VW-1:0] d3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (adv) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sc3_ff    <= sc2_ff;
         ec3_ff    <= ec2_ff;
         sum3_ff   <= sum2_ff;
         msum3_ff  <= msum2_ff;
         alpha3_ff <= alpha2_ff;
         seg3_ff   <= seg2_ff;
         eqrgb3_ff <= eqrgb2_ff;
         w3_ff     <= w2_ff;
         d3_ff     <= d2;
      end
   end

   // midpoint numerators (A - D) * 2^F over denominator FULL - D
   logic [NW1-1:0] num3 [spcl_pkg::LANES];
   logic [VW-1:0]  den3;
   logic           denz3;
   logic [SW1-1:0] side3;

   always_comb begin
      logic [VW-1:0] a_minus_d;
      den3  = FULL - d3_ff;
      denz3 = (den3 == '0);
      for (int i = 0; i < spcl_pkg::LANES; i++) begin
         a_minus_d = VW'({sum3_ff[i], {(F-1){1'b0}}}) - d3_ff;
         num3[i]   = {a_minus_d, {F{1'b0}}};
      end
      side3 = {denz3, eqrgb3_ff, seg3_ff, w3_ff, alpha3_ff, msum3_ff,
               ec3_ff[spcl_pkg::BLUE], ec3_ff[spcl_pkg::GREEN], ec3_ff[spcl_pkg::RED],
               sc3_ff[spcl_pkg::BLUE], sc3_ff[spcl_pkg::GREEN], sc3_ff[spcl_pkg::RED]};
   end

   logic           v3d;
   logic [QW-1:0]  q3d [spcl_pkg::LANES];
   logic [SW1-1:0] side3d;

   spcl_div_pipe #(.NW(NW1), .DW(VW), .QW(QW), .SW(SW1)) u_div_mid (
      .clock     (clock),
      .reset     (reset),
      .enable    (adv),
      .in_valid  (v3_ff),
      .in_num    (num3),
      .in_den    (den3),
      .in_side   (side3),
      .out_valid (v3d),
      .out_quot  (q3d),
      .out_side  (side3d)
   );

   // ---------------- stage 4: ratios to the largest channel ----------------
   logic          v4_ff;
   logic [QW-1:0] q4_ff [spcl_pkg::LANES];
   logic [QW-1:0] qmax4_ff;
   logic [SW1-1:0] side4_ff;
   logic [QW-1:0] qz [spcl_pkg::LANES];
   logic [QW-1:0] qmax;

   always_comb begin
      for (int i = 0; i < spcl_pkg::LANES; i++) begin
         qz[i] = side3d[SW1-1] ? '0 : q3d[i];
      end
      qmax = qz[spcl_pkg::RED];
      if (qz[spcl_pkg::GREEN] > qmax) qmax = qz[spcl_pkg::GREEN];
      if (qz[spcl_pkg::BLUE] > qmax)  qmax = qz[spcl_pkg::BLUE];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (adv) begin
         v4_ff <= v3d;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         q4_ff    <= qz;
         qmax4_ff <= qmax;
         side4_ff <= side3d;
      end
   end

   logic [NW2-1:0] num4 [spcl_pkg::LANES];
   logic [SW2-1:0] side4;

   always_comb begin
      for (int i = 0; i < spcl_pkg::LANES; i++) begin
         num4[i] = {q4_ff[i], {F{1'b0}}};
      end
      side4 = {(qmax4_ff == '0), side4_ff};
   end

   logic           v4d;
   logic [QW-1:0]  r4d [spcl_pkg::LANES];
   logic [SW2-1:0] side4d;

   spcl_div_pipe #(.NW(NW2), .DW(QW), .QW(QW), .SW(SW2)) u_div_ratio (
      .clock     (clock),
      .reset     (reset),
      .enable    (adv),
      .in_valid  (v4_ff),
      .in_num    (num4),
      .in_den    (qmax4_ff),
      .in_side   (side4),
      .out_valid (v4d),
      .out_quot  (r4d),
      .out_side  (side4d)
   );

   // unpack the sideband
   logic          cz5, dz5, eqrgb5, seg5;
   logic [TW-1:0] w5;
   logic [7:0]    alpha5;
   logic [8:0]    msum5;
   logic [7:0]    sc5 [spcl_pkg::LANES];
   logic [7:0]    ec5 [spcl_pkg::LANES];

   assign {cz5, dz5, eqrgb5, seg5, w5, alpha5, msum5,
           ec5[spcl_pkg::BLUE], ec5[spcl_pkg::GREEN], ec5[spcl_pkg::RED],
           sc5[spcl_pkg::BLUE], sc5[spcl_pkg::GREEN], sc5[spcl_pkg::RED]} = side4d;

   // rescaled midpoint Cp = r * M / 2^F, M = msum * 2^(F-1)
   logic [VW-1:0] cp5 [spcl_pkg::LANES];

   always_comb begin
      logic [F+9:0] rp;
      for (int i = 0; i < spcl_pkg::LANES; i++) begin
         rp     = r4d[i] * msum5;
         cp5[i] = (cz5 || dz5) ? '0 : rp[F+8:1];
      end
   end

   // ---------------- stage 5 ----------------
   logic          v5_ff;
   logic [VW-1:0] cp5_ff [spcl_pkg::LANES];
   logic [7:0]    sc5_ff [spcl_pkg::LANES];
   logic [7:0]    ec5_ff [spcl_pkg::LANES];
   logic          seg5_ff, eqrgb5_ff;
   logic [TW-1:0] w5_ff;
   logic [7:0]    alpha5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (adv) begin
         v5_ff <= v4d;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cp5_ff    <= cp5;
         sc5_ff    <= sc5;
         ec5_ff    <= ec5;
         seg5_ff   <= seg5;
         eqrgb5_ff <= eqrgb5;
         w5_ff     <= w5;
         alpha5_ff <= alpha5;
      end
   end

   // segment lerp: magnitude of the step times the weight
   logic [VW-1:0]   base5 [spcl_pkg::LANES];
   logic            neg5  [spcl_pkg::LANES];
   logic [VW+TW-1:0] prod5 [spcl_pkg::LANES];

   always_comb begin
      logic [VW-1:0] sv, ev, mag;
      logic [VW:0]   diff;
      for (int i = 0; i < spcl_pkg::LANES; i++) begin
         sv = {sc5_ff[i], {F{1'b0}}};
         ev = {ec5_ff[i], {F{1'b0}}};
         if (seg5_ff) begin
            diff     = {1'b0, ev} - {1'b0, cp5_ff[i]};
            base5[i] = cp5_ff[i];
         end else begin
            diff     = {1'b0, cp5_ff[i]} - {1'b0, sv};
            base5[i] = sv;
         end
         neg5[i]  = diff[VW];
         mag      = neg5[i] ? VW'(-diff) : diff[VW-1:0];
         prod5[i] = mag * w5_ff;
      end
   end

   // ---------------- stage 6 ----------------
   logic             v6_ff;
   logic [VW-1:0]    base6_ff [spcl_pkg::LANES];
   logic             neg6_ff  [spcl_pkg::LANES];
   logic [VW+TW-1:0] prod6_ff [spcl_pkg::LANES];
   logic [7:0]       ec6_ff   [spcl_pkg::LANES];
   logic             eqrgb6_ff;
   logic [7:0]       alpha6_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else if (adv) begin
         v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         base6_ff  <= base5;
         neg6_ff   <= neg5;
         prod6_ff  <= prod5;
         ec6_ff    <= ec5_ff;
         eqrgb6_ff <= eqrgb5_ff;
         alpha6_ff <= alpha5_ff;
      end
   end

   // apply the truncated step; the result stays inside 0..255*2^F
   logic [7:0] rgb6 [spcl_pkg::LANES];

   always_comb begin
      logic [VW-1:0] p;
      logic [VW:0]   o;
      for (int i = 0; i < spcl_pkg::LANES; i++) begin
         p = prod6_ff[i][VW+F-1:F];
         o = neg6_ff[i] ? ({1'b0, base6_ff[i]} - {1'b0, p})
                        : ({1'b0, base6_ff[i]} + {1'b0, p});
         rgb6[i] = eqrgb6_ff ? ec6_ff[i] : o[F+7:F];
      end
   end

   // ---------------- output register ----------------
   logic        rsp_vld_ff;
   logic [31:0] rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (adv) begin
         rsp_vld_ff <= v6_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff <= {alpha6_ff, rgb6[spcl_pkg::BLUE], rgb6[spcl_pkg::GREEN],
                         rgb6[spcl_pkg::RED]};
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
